@@ rtl/core/lpr_pkg.sv @@
`timescale 1ns / 1ps

package lpr_pkg;

  // Fixed field widths of the ports
  localparam int unsigned PAGE_W   = 16;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned RES_W    = 5;
  localparam int unsigned LIMIT_W  = 5;

  // Configuration port
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 3;

  // Register index, taken from paddr[2]
  localparam logic REG_FRAMES_IN_USE = 1'b0;

  localparam logic [LIMIT_W-1:0] FRAMES_IN_USE_RESET = LIMIT_W'(16);

  // Per-cell control from the top level
  typedef struct packed {
    logic shift;     // load the neighbor's page this cycle
    logic occupied;  // cell holds a resident page
  } cell_ctrl_t;

endpackage

@@ rtl/core/lru_page_replacement_core.sv @@
`timescale 1ns / 1ps

// Fully associative LRU page replacement. Resident pages sit in a row of
// FRAMES cells ordered by recency, cell 0 the most recent. Every reference is
// compared against all resident cells in the cycle it is accepted, and the
// row shifts by one place toward the tail in that same cycle, so one
// reference is taken per clock while the output register is free or being
// read: the result appears in the output register in the cycle after
// acceptance, and a new reference is accepted while that result waits as
// long as it is taken in the same cycle. The limit register frames_in_use
// (address 0) is clamped to 1..FRAMES; lowering it below the current
// occupancy flushes nothing, misses then replace the tail page.
module lru_page_replacement_core #(
  parameter int unsigned FRAMES    = 16,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // reference channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [lpr_pkg::PAGE_W-1:0]     in_page,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_fault,
  output logic                           out_evicted_valid,
  output logic [lpr_pkg::PAGE_W-1:0]     out_evicted_page,
  output logic [lpr_pkg::COUNT_W-1:0]    out_fault_count,
  output logic [lpr_pkg::RES_W-1:0]      out_resident_count,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lpr_pkg::APB_AW-1:0]     paddr,
  input  logic [lpr_pkg::APB_DW-1:0]     pwdata,
  output logic [lpr_pkg::APB_DW-1:0]     prdata,
  output logic                           pready
);
  import lpr_pkg::*;

  localparam int unsigned OCC_W = $clog2(FRAMES + 1);

  // Configuration register
  logic [LIMIT_W-1:0] frames_in_use_r;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_FRAMES_IN_USE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_in_use_r <= FRAMES_IN_USE_RESET;
    end else if (cfg_wr) begin
      frames_in_use_r <= pwdata[LIMIT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_FRAMES_IN_USE) begin
      prdata = APB_DW'(frames_in_use_r);
    end
  end

  // Clamp the limit to 1..FRAMES
  logic [OCC_W-1:0] limit;
  always_comb begin
    priority if (frames_in_use_r == '0) begin
      limit = OCC_W'(1);
    end else if (32'(frames_in_use_r) > FRAMES) begin
      limit = OCC_W'(FRAMES);
    end else begin
      limit = OCC_W'(frames_in_use_r);
    end
  end

  // Handshake
  logic out_valid_r;
  logic in_fire;
  logic out_fire;

  assign out_fire = out_valid_r && out_ready;
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Request page, zero-extended then cut to PAGE_BITS
  logic [31:0]          in_ext;
  logic [PAGE_BITS-1:0] req_page;
  assign in_ext   = 32'(in_page);
  assign req_page = in_ext[PAGE_BITS-1:0];

  // Cell row
  logic [OCC_W-1:0]     occ_r;
  logic [OCC_W-1:0]     occ_nxt;
  cell_ctrl_t           ctrl      [FRAMES];
  logic [PAGE_BITS-1:0] cell_page [FRAMES];
  logic [PAGE_BITS-1:0] nb_page   [FRAMES];
  logic [FRAMES:0]      found;
  logic                 hit;
  logic                 evict;

  assign found[0] = 1'b0;
  assign hit      = found[FRAMES];
  assign evict    = !hit && (occ_r >= limit);

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign nb_page[i] = req_page;
    end else begin : g_body
      assign nb_page[i] = cell_page[i-1];
    end

    // Shift down to the hit cell, or to the tail / first free cell on a miss
    always_comb begin
      ctrl[i].occupied = OCC_W'(i) < occ_r;
      if (hit) begin
        ctrl[i].shift = in_fire && !found[i];
      end else if (evict) begin
        ctrl[i].shift = in_fire && (OCC_W'(i) < occ_r);
      end else begin
        ctrl[i].shift = in_fire && (OCC_W'(i) <= occ_r);
      end
    end

    lpr_cell #(
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl[i]),
      .req_page  (req_page),
      .nb_page   (nb_page[i]),
      .found_in  (found[i]),
      .page_out  (cell_page[i]),
      .found_out (found[i+1])
    );
  end

  // Select the tail page for eviction
  logic [OCC_W-1:0]     tail_idx;
  logic [PAGE_BITS-1:0] tail_page;
  assign tail_idx = occ_r - OCC_W'(1);

  always_comb begin
    tail_page = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (OCC_W'(i) == tail_idx) begin
        tail_page = tail_page | cell_page[i];
      end
    end
  end

  // Occupancy and fault counter
  logic [COUNT_W-1:0] faults_r;
  logic [COUNT_W-1:0] faults_nxt;

  always_comb begin
    occ_nxt    = occ_r;
    faults_nxt = faults_r;
    if (!hit) begin
      if (faults_r != '1) begin
        faults_nxt = faults_r + COUNT_W'(1);
      end
      if (!evict) begin
        occ_nxt = occ_r + OCC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r    <= '0;
      faults_r <= '0;
    end else if (in_fire) begin
      occ_r    <= occ_nxt;
      faults_r <= faults_nxt;
    end
  end

  // Result register
  logic               fault_r;
  logic               ev_valid_r;
  logic [PAGE_W-1:0]  ev_page_r;
  logic [COUNT_W-1:0] fcount_r;
  logic [RES_W-1:0]   res_r;
  logic [31:0]        ev_ext;

  assign ev_ext = evict ? 32'(tail_page) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fault_r    <= !hit;
      ev_valid_r <= evict;
      ev_page_r  <= ev_ext[PAGE_W-1:0];
      fcount_r   <= faults_nxt;
      res_r      <= RES_W'(occ_nxt);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_fault          = fault_r;
  assign out_evicted_valid  = ev_valid_r;
  assign out_evicted_page   = ev_page_r;
  assign out_fault_count    = fcount_r;
  assign out_resident_count = res_r;

  // Checks
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(occ_r) <= FRAMES)
    else $error("occupancy above frame count");

  a_hit_keeps_occ: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && hit |=> occ_r == $past(occ_r))
    else $error("hit changed occupancy");

  a_evict_is_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ev_valid_r |-> fault_r)
    else $error("eviction without fault");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> faults_r >= $past(faults_r))
    else $error("fault counter went backwards");

endmodule

@@ rtl/core/lpr_cell.sv @@
`timescale 1ns / 1ps

module lpr_cell #(
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                  clk,
  input  lpr_pkg::cell_ctrl_t   ctrl,
  input  logic [PAGE_BITS-1:0]  req_page,
  input  logic [PAGE_BITS-1:0]  nb_page,
  input  logic                  found_in,
  output logic [PAGE_BITS-1:0]  page_out,
  output logic                  found_out
);
  import lpr_pkg::*;

  logic [PAGE_BITS-1:0] page_r;
  logic [PAGE_BITS-1:0] page_nxt;
  logic                 match;

  // Compare the stored page with the reference
  assign match     = ctrl.occupied && (page_r == req_page);
  assign found_out = found_in | match;
  assign page_out  = page_r;

  // Take the neighbor's page on a shift, else hold
  assign page_nxt = ctrl.shift ? nb_page : page_r;

  always_ff @(posedge clk) begin
    page_r <= page_nxt;
  end

endmodule
